FILE: hdl/rrb_pkg.sv
package rrb_pkg;

    localparam int SEQ_W          = 16;
    localparam int REORDER_DEPTH_DEF = 32;
    localparam logic [SEQ_W-1:0] RESET_EXPECTED = 16'd1;

    localparam logic RESULT_DELIVER = 1'b0;
    localparam logic RESULT_ACK     = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0] sequence_number;
        logic [SEQ_W-1:0] payload_length;
        logic [SEQ_W-1:0] payload_handle;
    } in_word_t;

    typedef struct packed {
        logic             result_kind;
        logic [SEQ_W-1:0] delivered_handle;
        logic [SEQ_W-1:0] delivered_length;
        logic [SEQ_W-1:0] ack_number;
        logic             last_result;
    } out_word_t;

    // One held packet, same layout as an arriving word.
    typedef in_word_t entry_t;

    // True when a is behind b in wrap-aware order (difference in -32767..-1).
    function automatic logic seq_behind(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1] && (d[SEQ_W-2:0] != '0);
    endfunction

endpackage

FILE: hdl/rrb_store.sv
module rrb_store
    import rrb_pkg::*;
#(
    parameter int DEPTH = REORDER_DEPTH_DEF,
    localparam int IW = $clog2(DEPTH)
)(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/receive_reorder_buffer_core.sv
// Channel  Direction  Payload     Handshake
// in       input      in_data     in_valid / in_stall
// out      output     out_data    out_valid / out_stall
// cfg      input      cfg_wdata   cfg_we (no wait)
//
// One word is taken at a time, only while the sequencer is idle and no register write is present.
// The held entries sit in one memory; a scan reads each held entry in turn,
// and each shifted entry is read, then written back; each drained entry is
// followed by one rescan of the held entries.
// Results leave through one output register, which stalls the sequencer only when full and stalled.
// Reset needs no clearing pass: the held count is zeroed and entries beyond it are never read.
module receive_reorder_buffer_core
    import rrb_pkg::*;
#(
    parameter int REORDER_DEPTH = REORDER_DEPTH_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_data,
    input  logic             cfg_we,
    input  logic [SEQ_W-1:0] cfg_wdata
);

    localparam int IW = $clog2(REORDER_DEPTH);
    localparam int CW = $clog2(REORDER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(REORDER_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(REORDER_DEPTH - 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_DELIN = 11'b00000000010,
        ST_DSCAN = 11'b00000000100,
        ST_DHIT  = 11'b00000001000,
        ST_DNRD  = 11'b00000010000,
        ST_DNWR  = 11'b00000100000,
        ST_FSCAN = 11'b00001000000,
        ST_UPRD  = 11'b00010000000,
        ST_UPWR  = 11'b00100000000,
        ST_INS   = 11'b01000000000,
        ST_ACK   = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [SEQ_W-1:0] expected_reg, expected_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic [CW-1:0]    pend_idx_reg, pend_idx_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic             found_reg, found_next;
    logic             dup_reg, dup_next;
    entry_t           pkt_reg, pkt_next;
    entry_t           hit_reg, hit_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;

    logic             rd_en, wr_en;
    logic [IW-1:0]    rd_addr, wr_addr;
    entry_t           wr_data, rd_data;
    logic             out_free, issue;
    logic [SEQ_W-1:0] diff_in;
    logic             in_future;
    logic [CW-1:0]    j_inc, j_dec, final_pos;

    rrb_store #(
        .DEPTH(REORDER_DEPTH)
    ) u_store (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE) || cfg_we;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign issue     = (scan_reg < count_reg);
    assign j_inc     = j_reg + 1'b1;
    assign j_dec     = j_reg - 1'b1;
    assign final_pos = found_reg ? pos_reg : count_reg;

    // Future means a wrap-aware difference in 1..32768.
    assign diff_in   = in_data.sequence_number - expected_reg;
    assign in_future = (diff_in != '0) && (!diff_in[SEQ_W-1] || (diff_in[SEQ_W-2:0] == '0));

    always_comb
    begin
        state_next     = state_reg;
        expected_next  = expected_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        dup_next       = dup_reg;
        pkt_next       = pkt_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = scan_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = j_reg[IW-1:0];
        wr_data        = rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    expected_next = cfg_wdata;
                    count_next    = '0;
                end
                else if (in_valid && (in_data.sequence_number != '0))
                begin
                    pkt_next  = in_data;
                    scan_next = '0;
                    found_next = 1'b0;
                    dup_next  = 1'b0;
                    if (in_data.sequence_number == expected_reg)
                    begin
                        expected_next = in_data.sequence_number + 1'b1;
                        state_next    = ST_DELIN;
                    end
                    else if (in_future)
                    begin
                        state_next = ST_FSCAN;
                    end
                    else
                    begin
                        state_next = ST_ACK;
                    end
                end
            end

            ST_DELIN:
            begin
                if (pkt_reg.payload_length == '0)
                begin
                    state_next = ST_DSCAN;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{RESULT_DELIVER, pkt_reg.payload_handle,
                                       pkt_reg.payload_length, '0, 1'b0};
                    state_next     = ST_DSCAN;
                end
            end

            ST_DSCAN:
            begin
                if (pend_reg && (rd_data.sequence_number == expected_reg))
                begin
                    hit_next   = rd_data;
                    j_next     = pend_idx_reg;
                    state_next = ST_DHIT;
                end
                else if (issue)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    scan_next     = scan_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = ST_ACK;
                end
            end

            ST_DHIT:
            begin
                if ((hit_reg.payload_length == '0) || out_free)
                begin
                    if (hit_reg.payload_length != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{RESULT_DELIVER, hit_reg.payload_handle,
                                           hit_reg.payload_length, '0, 1'b0};
                    end
                    expected_next = hit_reg.sequence_number + 1'b1;
                    state_next    = ST_DNRD;
                end
            end

            ST_DNRD:
            begin
                if (j_inc < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_inc[IW-1:0];
                    state_next = ST_DNWR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    scan_next  = '0;
                    state_next = ST_DSCAN;
                end
            end

            ST_DNWR:
            begin
                wr_en      = 1'b1;
                j_next     = j_inc;
                state_next = ST_DNRD;
            end

            ST_FSCAN:
            begin
                if (pend_reg)
                begin
                    if (rd_data.sequence_number == pkt_reg.sequence_number)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!found_reg && seq_behind(pkt_reg.sequence_number,
                                                 rd_data.sequence_number))
                    begin
                        found_next = 1'b1;
                        pos_next   = pend_idx_reg;
                    end
                end
                if (issue)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg;
                    scan_next     = scan_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    pos_next = final_pos;
                    if (dup_reg)
                    begin
                        state_next = ST_ACK;
                    end
                    else if (count_reg < DEPTH_C)
                    begin
                        j_next     = count_reg;
                        count_next = count_reg + 1'b1;
                        state_next = ST_UPRD;
                    end
                    else if (final_pos < LAST_C)
                    begin
                        // Full buffer: the last entry falls off the end.
                        j_next     = LAST_C;
                        state_next = ST_UPRD;
                    end
                    else
                    begin
                        state_next = ST_ACK;
                    end
                end
            end

            ST_UPRD:
            begin
                if (j_reg > pos_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_dec[IW-1:0];
                    state_next = ST_UPWR;
                end
                else
                begin
                    state_next = ST_INS;
                end
            end

            ST_UPWR:
            begin
                wr_en      = 1'b1;
                j_next     = j_dec;
                state_next = ST_UPRD;
            end

            ST_INS:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[IW-1:0];
                wr_data    = pkt_reg;
                state_next = ST_ACK;
            end

            ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{RESULT_ACK, '0, '0, expected_reg, 1'b1};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            expected_reg  <= RESET_EXPECTED;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        j_reg        <= j_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        dup_reg      <= dup_next;
        pkt_reg      <= pkt_next;
        hit_reg      <= hit_next;
        out_data_reg <= out_data_next;
    end

    // The held count never grows past the buffer depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("held count beyond depth");

    // A result is never loaded over one that is still stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result overwritten");

    // Memory writes happen only during shifts and the insert.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_DNWR || state_reg == ST_UPWR || state_reg == ST_INS))
        else $error("memory write outside shift or insert");

    // Each word taken in with a nonzero sequence number starts work, so the input is stalled in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !cfg_we && (in_data.sequence_number != '0)) |=> in_stall)
        else $error("input taken without starting work");

endmodule
